// ===== hdl/ucm_pkg.sv =====
package ucm_pkg;

    localparam int RANGE_ENTRIES_DEF = 256;
    localparam int TITLE_PAIRS_DEF   = 32;

    localparam logic [2:0] OP_UPPER      = 3'd0;
    localparam logic [2:0] OP_LOWER      = 3'd1;
    localparam logic [2:0] OP_TITLE      = 3'd2;
    localparam logic [2:0] OP_LOAD_UPPER = 3'd3;
    localparam logic [2:0] OP_LOAD_LOWER = 3'd4;
    localparam logic [2:0] OP_LOAD_TITLE = 3'd5;

    localparam logic [1:0] CFG_UPPER_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOWER_COUNT = 2'd1;
    localparam logic [1:0] CFG_TITLE_COUNT = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] code_unit;
        logic [7:0]  entry_index;
        logic [15:0] range_low;
        logic [7:0]  range_span;
        logic [7:0]  range_step;
        logic [15:0] range_delta;
        logic [15:0] title_from;
        logic [15:0] title_to;
    } t_in_word;

    typedef struct packed {
        logic [15:0] mapped_unit;
        logic        was_changed;
    } t_out_word;

    typedef struct packed {
        logic [15:0] low;
        logic [7:0]  span;
        logic [7:0]  step;
        logic [15:0] delta;
    } t_range_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_CMP, S_MOD, S_TSCAN_RD, S_TSCAN_CMP, S_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [16:0] dividend;
        logic [7:0]  divisor;
    } t_mod_req;

    function automatic logic caseless(input logic [15:0] u);
        return (u >= 16'h2500 && u <= 16'hFEFF) || (u >= 16'h0600 && u <= 16'h0FFF) ||
               (u >= 16'h1100 && u <= 16'h1DFF) || (u >= 16'h2000 && u <= 16'h20FF) ||
               (u >= 16'h2200 && u <= 16'h23FF);
    endfunction

endpackage

// ===== hdl/ucm_mod_unit.sv =====
module ucm_mod_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ucm_pkg::t_mod_req i_req,
    output logic            o_busy,
    output logic            o_zero
);
    import ucm_pkg::*;

    // restoring remainder, one dividend bit per cycle
    logic [16:0] r_num, n_num;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;
    logic [9:0]  trial;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        trial = {r_rem, r_num[16]};
        if (i_req.start) begin
            n_num = i_req.dividend;
            n_rem = '0;
            n_div = i_req.divisor;
            n_cnt = 5'd17;
        end else if (r_cnt != 5'd0) begin
            n_num = {r_num[15:0], 1'b0};
            n_rem = (trial >= {2'b00, r_div}) ? 9'(trial - {2'b00, r_div}) : trial[8:0];
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = (r_cnt != 5'd0);
    assign o_zero = (r_rem == 9'd0);
endmodule

// ===== hdl/unicode_case_mapper.sv =====
// Unicode case mapper: converts one 16-bit code unit to upper, lower or
// title case, and takes load words that fill its range and title tables.
//
// Channels: input words on i_in_valid/o_in_ready, results on
// o_out_valid/i_out_ready, register writes on i_cfg_valid/o_cfg_ready.
// Conversion opcodes give one result word; load and unused opcodes give none.
//
// Sequence: ASCII and caseless units go straight to the result. A table lookup
// does a binary search with a read and a compare per probe (up to 9 probes
// for 256 entries, plus one closing check), then a pass through the shared
// remainder unit when the hit entry has a step, then, for the title opcode, a read
// and a compare per title pair scanned.
// One word is in flight at a time; o_in_ready is low while it is worked on.
//
// Reset clears the sequencer and counts; table contents stay undefined
// until loaded. A stalled receiver holds the result in the output register,
// and the next input word is not taken until the result is delivered.
module unicode_case_mapper #(
    parameter int RANGE_ENTRIES = ucm_pkg::RANGE_ENTRIES_DEF,
    parameter int TITLE_PAIRS   = ucm_pkg::TITLE_PAIRS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ucm_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ucm_pkg::t_out_word o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data
);
    import ucm_pkg::*;

    localparam int RW = $clog2(RANGE_ENTRIES);
    localparam int TW = $clog2(TITLE_PAIRS);

    // storage: one memory per table, registered read
    t_range_entry upper_mem [RANGE_ENTRIES];
    t_range_entry lower_mem [RANGE_ENTRIES];
    logic [31:0]  title_mem [TITLE_PAIRS];

    logic [8:0] r_ucnt, r_lcnt;
    logic [5:0] r_tcnt;

    t_state r_state, n_state;
    logic [2:0]  r_op;
    logic [15:0] r_unit;
    logic        r_sel_lower;
    logic [RW:0] r_lo, n_lo, r_hi, n_hi;
    logic [15:0] r_res, n_res;
    logic [8:0]  r_tidx, n_tidx;
    t_range_entry r_ent;
    logic [31:0] r_pair;
    t_out_word   r_out;
    logic        r_out_valid;

    logic [RW:0] mid;
    logic [RW:0] range_lim;
    logic [8:0]  title_lim;
    logic        accept;
    logic [16:0] top;
    t_mod_req    mod_req;
    logic        mod_busy, mod_zero;
    logic        finish;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign mid         = (RW+1)'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);

    // saturate counts to the table depth
    always_comb begin
        logic [8:0] c;
        c = r_sel_lower ? r_lcnt : r_ucnt;
        range_lim = (32'(c) > RANGE_ENTRIES) ? (RW+1)'(RANGE_ENTRIES) : (RW+1)'(c);
        title_lim = (32'(r_tcnt) > TITLE_PAIRS) ? 9'(TITLE_PAIRS) : 9'(r_tcnt);
    end

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (accept && 32'(i_in_data.entry_index) < RANGE_ENTRIES) begin
            if (i_in_data.opcode == OP_LOAD_UPPER)
                upper_mem[RW'(i_in_data.entry_index)] <= {i_in_data.range_low,
                    i_in_data.range_span, i_in_data.range_step, i_in_data.range_delta};
            if (i_in_data.opcode == OP_LOAD_LOWER)
                lower_mem[RW'(i_in_data.entry_index)] <= {i_in_data.range_low,
                    i_in_data.range_span, i_in_data.range_step, i_in_data.range_delta};
        end
        if (accept && i_in_data.opcode == OP_LOAD_TITLE
            && 32'(i_in_data.entry_index) < TITLE_PAIRS)
            title_mem[TW'(i_in_data.entry_index)] <= {i_in_data.title_from,
                                                      i_in_data.title_to};
        if (r_state == S_RD)
            r_ent <= r_sel_lower ? lower_mem[mid[RW-1:0]] : upper_mem[mid[RW-1:0]];
        if (r_state == S_TSCAN_RD)
            r_pair <= title_mem[r_tidx[TW-1:0]];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucnt <= '0;
            r_lcnt <= '0;
            r_tcnt <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UPPER_COUNT: r_ucnt <= i_cfg_data;
                CFG_LOWER_COUNT: r_lcnt <= i_cfg_data;
                CFG_TITLE_COUNT: r_tcnt <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign top = {1'b0, r_ent.low} + {9'd0, r_ent.span};
    assign mod_req.start    = (r_state == S_CMP) && (r_lo < r_hi) &&
                              !({1'b0, r_unit} > top) && !(r_unit < r_ent.low) &&
                              (r_ent.step != 8'd0);
    assign mod_req.dividend = {1'b0, 16'(r_unit - r_ent.low)};
    assign mod_req.divisor  = r_ent.step;

    ucm_mod_unit u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mod_req),
        .o_busy (mod_busy),
        .o_zero (mod_zero)
    );

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_res   = r_res;
        n_tidx  = r_tidx;
        finish  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = i_in_data.code_unit;
                    n_lo  = '0;
                    n_hi  = '0;
                    n_tidx = '0;
                    if (i_in_data.opcode == OP_UPPER || i_in_data.opcode == OP_LOWER ||
                        i_in_data.opcode == OP_TITLE) begin
                        if ((i_in_data.code_unit & 16'hFF80) == 16'h0000) begin
                            if (i_in_data.opcode == OP_LOWER) begin
                                if (i_in_data.code_unit >= 16'h0041 &&
                                    i_in_data.code_unit <= 16'h005A)
                                    n_res = i_in_data.code_unit + 16'h0020;
                            end else if (i_in_data.code_unit >= 16'h0061 &&
                                         i_in_data.code_unit <= 16'h007A) begin
                                n_res = i_in_data.code_unit - 16'h0020;
                            end
                            n_state = S_DONE;
                        end else if (caseless(i_in_data.code_unit)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_WAIT;
                        end
                    end
                end
            end
            S_WAIT: begin
                n_hi    = range_lim;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = (r_lo < r_hi) ? S_CMP : S_CMP;
            end
            S_CMP: begin
                if (!(r_lo < r_hi)) begin
                    n_state = S_TSCAN_RD;
                end else if ({1'b0, r_unit} > top) begin
                    n_lo = mid + 1'b1;
                    n_state = S_RD;
                end else if (r_unit < r_ent.low) begin
                    n_hi = mid;
                    n_state = S_RD;
                end else if (r_ent.step != 8'd0) begin
                    n_state = S_MOD;
                end else begin
                    n_res = r_unit + r_ent.delta;
                    n_state = S_TSCAN_RD;
                end
            end
            S_MOD: begin
                if (!mod_busy) begin
                    if (mod_zero) n_res = r_unit + r_ent.delta;
                    n_state = S_TSCAN_RD;
                end
            end
            S_TSCAN_RD: begin
                // title scan only for title opcode and result in 0x01C0..0x01FF
                if (r_op != OP_TITLE || (r_res & 16'hFFC0) != 16'h01C0 ||
                    r_tidx >= title_lim)
                    n_state = S_DONE;
                else
                    n_state = S_TSCAN_CMP;
            end
            S_TSCAN_CMP: begin
                if (r_pair[31:16] == r_res) begin
                    n_res = r_pair[15:0];
                    n_state = S_DONE;
                end else begin
                    n_tidx = r_tidx + 9'd1;
                    n_state = S_TSCAN_RD;
                end
            end
            S_DONE: begin
                finish  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_res <= n_res;
        r_tidx <= n_tidx;
        if (accept) begin
            r_op        <= i_in_data.opcode;
            r_unit      <= i_in_data.code_unit;
            r_sel_lower <= (i_in_data.opcode == OP_LOWER);
        end
        if (finish) begin
            r_out.mapped_unit <= r_res;
            r_out.was_changed <= (r_res != r_unit);
        end
    end
endmodule

// ===== hdl/ucm_checker.sv =====
module ucm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ucm_pkg::t_out_word o_out_data
);
    import ucm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped under stall");

    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");

    // a result only rises after the input side has been closed
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised while input side was open");
endmodule

bind unicode_case_mapper ucm_checker u_ucm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
